>>> rtl/core/smo_pkg.sv
// Shared types and constants for the sparse memory object emitter.
`timescale 1ns / 1ps
package smo_pkg;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_DEFINE = 2'd1;
    localparam logic [1:0] REQ_FETCH  = 2'd2;
    localparam logic [1:0] REQ_EMIT   = 2'd3;

    localparam logic [3:0] PH_MAGIC0   = 4'd0;
    localparam logic [3:0] PH_MAGIC1   = 4'd1;
    localparam logic [3:0] PH_MAGIC2   = 4'd2;
    localparam logic [3:0] PH_MAGIC3   = 4'd3;
    localparam logic [3:0] PH_ENTRY_HI = 4'd4;
    localparam logic [3:0] PH_ENTRY_LO = 4'd5;
    localparam logic [3:0] PH_COUNT    = 4'd6;
    localparam logic [3:0] PH_ADDR_HI  = 4'd7;
    localparam logic [3:0] PH_ADDR_LO  = 4'd8;
    localparam logic [3:0] PH_WORD_HI  = 4'd9;
    localparam logic [3:0] PH_WORD_LO  = 4'd10;

    localparam logic [7:0] MAGIC [4] = '{8'h4F, 8'h42, 8'h4A, 8'h38};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC,
        ST_SEEK,
        ST_SEEKCHK,
        ST_MEAS,
        ST_MEASCHK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic acc;
        logic seek_end;
        logic seek_hit;
        logic seek_miss;
        logic meas_inc;
        logic meas_fin;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_type;
        logic       addr_ok;
        logic [1:0] req_type;
        logic [3:0] phase;
        logic       pos_ge_end;
        logic       pos1_ge_end;
        logic       scan_end;
        logic       meas_stop;
        logic       rmark;
        logic       clr_last;
    } t_stat;

endpackage

>>> rtl/core/smo_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface smo_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] word_address;
    logic [11:0] word_value;
    logic        allow_redefine;
    modport source (output valid, req_type, word_address, word_value, allow_redefine,
                    input ready);
    modport sink (input valid, req_type, word_address, word_value, allow_redefine,
                  output ready);
endinterface

interface smo_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] read_word;
    logic [7:0]  stream_byte;
    logic        byte_valid;
    logic        stream_last;
    logic        redefine_error;
    logic [15:0] error_total;
    modport source (output valid, read_word, stream_byte, byte_valid, stream_last,
                    redefine_error, error_total, input ready);
    modport sink (input valid, read_word, stream_byte, byte_valid, stream_last,
                  redefine_error, error_total, output ready);
endinterface

>>> rtl/core/smo_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module smo_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/smo_dp.sv
// Datapath: word/mark store, emit pointers, error counter and result registers.
`timescale 1ns / 1ps
module smo_dp import smo_pkg::*; #(
    parameter int MEM_WORDS     = 4096,
    parameter int MAX_RUN_WORDS = 126
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_req_type,
    input  logic [11:0] i_word_address,
    input  logic [11:0] i_word_value,
    input  logic        i_allow_redefine,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    output logic [11:0] o_entry,
    output logic [11:0] o_read_word,
    output logic [7:0]  o_stream_byte,
    output logic        o_byte_valid,
    output logic        o_stream_last,
    output logic        o_redefine_error,
    output logic [15:0] o_error_total
);
    localparam int AW = $clog2(MEM_WORDS);
    localparam int PW = AW + 1;

    logic [11:0]   r_entry;
    logic [1:0]    r_type;
    logic [AW-1:0] r_addr;
    logic [11:0]   r_val;
    logic          r_allow;
    logic [3:0]    r_phase;
    logic [PW-1:0] r_pos, r_run_end, r_scan;
    logic [AW-1:0] r_clr_addr;
    logic [15:0]   r_err;
    logic [11:0]   r_rd;
    logic [7:0]    r_sb;
    logic          r_bv, r_last, r_rerr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [12:0]   ram_wdata, ram_rdata;
    logic [PW-1:0] pos1, run_len;
    logic [12:0]   pos13;
    logic          in_addr_ok;

    assign pos1    = r_pos + PW'(1);
    assign run_len = r_scan - r_pos;
    assign pos13   = 13'(r_pos);
    assign in_addr_ok = {20'd0, i_word_address} < 32'(MEM_WORDS);

    // Read address: request address or emit position at a transfer, else the scan pointer
    always_comb begin
        if (i_cmd.accept && i_req_type != REQ_EMIT) begin
            ram_raddr = i_word_address[AW-1:0];
        end else if (i_cmd.accept) begin
            ram_raddr = r_pos[AW-1:0];
        end else begin
            ram_raddr = r_scan[AW-1:0];
        end
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = 13'd0;
        if (i_cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.acc && r_type == REQ_DEFINE) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = {1'b1, r_val};
        end
    end

    smo_ram #(.WIDTH(13), .DEPTH(MEM_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (1'b1),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry    <= 12'd0;
            r_phase    <= PH_MAGIC0;
            r_pos      <= '0;
            r_run_end  <= '0;
            r_scan     <= '0;
            r_clr_addr <= '0;
            r_err      <= 16'd0;
            r_type     <= REQ_CLEAR;
        end else begin
            if (i_cfg_we) begin
                r_entry <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.accept) begin
                r_type  <= i_req_type;
                r_addr  <= i_word_address[AW-1:0];
                r_val   <= i_word_value;
                r_allow <= i_allow_redefine;
                r_rd    <= 12'd0;
                r_bv    <= (i_req_type == REQ_EMIT);
                r_last  <= 1'b0;
                r_rerr  <= 1'b0;
                case (i_req_type)
                    REQ_CLEAR: begin
                        r_sb       <= 8'd0;
                        r_clr_addr <= '0;
                        r_phase    <= PH_MAGIC0;
                        r_pos      <= '0;
                        r_run_end  <= '0;
                    end
                    REQ_EMIT: begin
                        case (r_phase)
                            PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3: begin
                                r_sb    <= MAGIC[r_phase[1:0]];
                                r_phase <= r_phase + 4'd1;
                            end
                            PH_ENTRY_HI: begin
                                r_sb    <= {2'b00, r_entry[11:6]};
                                r_phase <= PH_ENTRY_LO;
                            end
                            PH_ENTRY_LO: begin
                                r_sb   <= {2'b00, r_entry[5:0]};
                                r_pos  <= '0;
                                r_scan <= '0;
                            end
                            PH_COUNT: begin
                                r_scan <= r_pos;
                            end
                            PH_ADDR_HI: begin
                                r_sb    <= {2'b00, pos13[11:6]};
                                r_phase <= PH_ADDR_LO;
                            end
                            PH_ADDR_LO: begin
                                r_sb <= {2'b00, pos13[5:0]};
                                if (r_pos >= r_run_end) begin
                                    r_scan <= r_pos;
                                end else begin
                                    r_phase <= PH_WORD_HI;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                        r_sb <= 8'd0;
                    end
                endcase
            end
            if (i_cmd.acc) begin
                case (r_type)
                    REQ_DEFINE: begin
                        if (ram_rdata[12] && !r_allow) begin
                            r_rerr <= 1'b1;
                            if (r_err != 16'hFFFF) begin
                                r_err <= r_err + 16'd1;
                            end
                        end
                    end
                    REQ_FETCH: begin
                        r_rd <= ram_rdata[12] ? ram_rdata[11:0] : 12'd0;
                    end
                    default: begin
                        if (r_phase == PH_WORD_HI) begin
                            r_sb    <= {2'b00, ram_rdata[11:6]};
                            r_phase <= PH_WORD_LO;
                        end else begin
                            r_sb  <= {2'b00, ram_rdata[5:0]};
                            r_pos <= pos1;
                            if (pos1 >= r_run_end) begin
                                r_scan <= pos1;
                            end else begin
                                r_phase <= PH_WORD_HI;
                            end
                        end
                    end
                endcase
            end
            if (i_cmd.seek_end) begin
                r_phase   <= PH_MAGIC0;
                r_pos     <= '0;
                r_run_end <= '0;
                r_last    <= 1'b1;
            end
            if (i_cmd.seek_hit) begin
                r_pos   <= r_scan;
                r_phase <= PH_COUNT;
            end
            if (i_cmd.seek_miss || i_cmd.meas_inc) begin
                r_scan <= r_scan + PW'(1);
            end
            if (i_cmd.meas_fin) begin
                r_run_end <= r_scan;
                r_sb      <= {run_len[6:0], 1'b0} + 8'd3;
                r_phase   <= PH_ADDR_HI;
            end
        end
    end

    always_comb begin
        o_stat.in_type     = i_req_type;
        o_stat.addr_ok     = in_addr_ok;
        o_stat.req_type    = r_type;
        o_stat.phase       = r_phase;
        o_stat.pos_ge_end  = r_pos >= r_run_end;
        o_stat.pos1_ge_end = pos1 >= r_run_end;
        o_stat.scan_end    = r_scan >= PW'(MEM_WORDS);
        o_stat.meas_stop   = (r_scan >= PW'(MEM_WORDS)) || (run_len >= PW'(MAX_RUN_WORDS));
        o_stat.rmark       = ram_rdata[12];
        o_stat.clr_last    = r_clr_addr == AW'(MEM_WORDS - 1);
    end

    assign o_entry          = r_entry;
    assign o_read_word      = r_rd;
    assign o_stream_byte    = r_sb;
    assign o_byte_valid     = r_bv;
    assign o_stream_last    = r_last;
    assign o_redefine_error = r_rerr;
    assign o_error_total    = r_err;
endmodule

>>> rtl/core/smo_ctrl.sv
// Controller: sequences clearing sweep, store accesses and the emit scans.
`timescale 1ns / 1ps
module smo_ctrl import smo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_ov, r_clr_res, n_clr_res;
    logic   xfer;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_ov || i_out_ready);
    assign xfer        = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;

    always_comb begin
        n_state   = r_state;
        n_clr_res = r_clr_res;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = r_clr_res ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (xfer) begin
                    case (i_stat.in_type)
                        REQ_CLEAR: begin
                            n_state   = ST_CLEAR;
                            n_clr_res = 1'b1;
                        end
                        REQ_DEFINE, REQ_FETCH: begin
                            n_state = i_stat.addr_ok ? ST_ACC : ST_DONE;
                        end
                        default: begin
                            case (i_stat.phase)
                                PH_ENTRY_LO: n_state = ST_SEEK;
                                PH_COUNT:    n_state = ST_MEAS;
                                PH_ADDR_LO:  n_state = i_stat.pos_ge_end ? ST_SEEK : ST_DONE;
                                PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3, PH_ENTRY_HI,
                                PH_ADDR_HI:
                                    n_state = ST_DONE;
                                default:     n_state = ST_ACC;
                            endcase
                        end
                    endcase
                end
            end
            ST_ACC: begin
                if (i_stat.req_type == REQ_EMIT && i_stat.phase != PH_WORD_HI &&
                    i_stat.pos1_ge_end) begin
                    n_state = ST_SEEK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SEEK:    n_state = i_stat.scan_end ? ST_DONE : ST_SEEKCHK;
            ST_SEEKCHK: n_state = i_stat.rmark ? ST_DONE : ST_SEEK;
            ST_MEAS:    n_state = i_stat.meas_stop ? ST_DONE : ST_MEASCHK;
            ST_MEASCHK: n_state = i_stat.rmark ? ST_MEAS : ST_DONE;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_CLEAR:   o_cmd.clr_step = 1'b1;
            ST_IDLE:    o_cmd.accept   = xfer;
            ST_ACC:     o_cmd.acc      = 1'b1;
            ST_SEEK:    o_cmd.seek_end = i_stat.scan_end;
            ST_SEEKCHK: begin
                o_cmd.seek_hit  = i_stat.rmark;
                o_cmd.seek_miss = !i_stat.rmark;
            end
            ST_MEAS:    o_cmd.meas_fin = i_stat.meas_stop;
            ST_MEASCHK: begin
                o_cmd.meas_inc = i_stat.rmark;
                o_cmd.meas_fin = !i_stat.rmark;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_res <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_res <= (r_state == ST_DONE) ? 1'b0 : n_clr_res;
            if (r_state == ST_DONE) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_xfer_clears_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |=> !r_ov) else $error("result still pending after new transfer");
    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_ov) else $error("finished request gave no result");
    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_in_ready) else $error("transfer taken during sweep");
`endif
endmodule

>>> rtl/core/sparse_memory_object_emitter.sv
// Top level of the sparse memory object emitter.
//
//   channel | direction | contents
//   i_in    | in        | req_type, word_address, word_value, allow_redefine
//   o_out   | out       | read_word, stream_byte, byte_valid, stream_last,
//           |           | redefine_error, error_total
//   APB     | in/out    | entry_address at byte 0
//
// Define and fetch read the store, then update; clear sweeps every store word.
// Header and address bytes need no store read; word bytes read the store first.
// Run search and run measurement read one store word at a time (one read port).
// After reset a sweep clears the marks; no request is taken then.
// A pending result does not block the next transfer if it is taken in the same cycle.
`timescale 1ns / 1ps
module sparse_memory_object_emitter import smo_pkg::*; #(
    parameter int MEM_WORDS     = 4096,
    parameter int MAX_RUN_WORDS = 126
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smo_in_if.sink      i_in,
    smo_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd        cmd;
    t_stat       stat;
    logic [11:0] entry;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {20'd0, entry};

    smo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    smo_dp #(.MEM_WORDS(MEM_WORDS), .MAX_RUN_WORDS(MAX_RUN_WORDS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_in.req_type),
        .i_word_address   (i_in.word_address),
        .i_word_value     (i_in.word_value),
        .i_allow_redefine (i_in.allow_redefine),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (pwdata[11:0]),
        .o_entry          (entry),
        .o_read_word      (o_out.read_word),
        .o_stream_byte    (o_out.stream_byte),
        .o_byte_valid     (o_out.byte_valid),
        .o_stream_last    (o_out.stream_last),
        .o_redefine_error (o_out.redefine_error),
        .o_error_total    (o_out.error_total)
    );
endmodule

>>> test/sparse_memory_object_emitter_tb.sv
// Self-checking testbench for the sparse memory object emitter.
`timescale 1ns / 1ps
module sparse_memory_object_emitter_tb;
    import smo_pkg::*;

    localparam int STORE_WORDS = 4096;
    localparam int RUN_LIMIT   = 126;
    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int RX_HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_SYNC,
        ACT_ENTRY,
        ACT_RX_HOLD
    } t_act;

    typedef struct {
        t_act        act;
        logic [1:0]  kind;
        logic [11:0] addr;
        logic [11:0] val;
        logic        allow;
        int          gap;
    } t_plan;

    typedef struct {
        logic [11:0] read_word;
        logic [7:0]  stream_byte;
        logic        byte_valid;
        logic        stream_last;
        logic        redefine_error;
        logic [15:0] error_total;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    smo_in_if  req_bus ();
    smo_out_if res_bus ();

    sparse_memory_object_emitter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_bus),
        .o_out   (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [11:0] store_word [STORE_WORDS];
    logic        store_mark [STORE_WORDS];
    logic [15:0] err_count;
    logic [3:0]  phase;
    int          pos;
    int          run_stop;
    logic [11:0] entry_reg;

    t_plan   req_plan [$];
    t_result expected_results [$];
    int      fail_count;
    int      n_items;
    int      cycles;
    int      res_count;
    logic    in_took;
    logic    out_took;
    logic    rx_hold_req;
    logic    feeding_done;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // moves to the next run; returns 1 when the stream has ended
    function automatic logic seek_run();
        int a;
        a = pos;
        while (a < STORE_WORDS && !store_mark[a]) a++;
        if (a >= STORE_WORDS) begin
            phase    = PH_MAGIC0;
            pos      = 0;
            run_stop = 0;
            return 1'b1;
        end
        pos   = a;
        phase = PH_COUNT;
        return 1'b0;
    endfunction

    function automatic t_result predict_result(input t_plan r);
        t_result res;
        int e;
        res = '{default: '0};
        case (r.kind)
            REQ_CLEAR: begin
                foreach (store_mark[i]) store_mark[i] = 1'b0;
                phase    = PH_MAGIC0;
                pos      = 0;
                run_stop = 0;
            end
            REQ_DEFINE: begin
                if (store_mark[r.addr] && !r.allow) begin
                    res.redefine_error = 1'b1;
                    if (err_count != 16'hFFFF) err_count++;
                end
                store_mark[r.addr] = 1'b1;
                store_word[r.addr] = r.val;
            end
            REQ_FETCH: begin
                if (store_mark[r.addr]) res.read_word = store_word[r.addr];
            end
            default: begin
                res.byte_valid = 1'b1;
                if (phase <= PH_MAGIC3) begin
                    res.stream_byte = MAGIC[phase[1:0]];
                    phase++;
                end else begin
                    case (phase)
                        PH_ENTRY_HI: begin
                            res.stream_byte = {2'b0, entry_reg[11:6]};
                            phase = PH_ENTRY_LO;
                        end
                        PH_ENTRY_LO: begin
                            res.stream_byte = {2'b0, entry_reg[5:0]};
                            pos = 0;
                            res.stream_last = seek_run();
                        end
                        PH_COUNT: begin
                            e = pos;
                            while (e < STORE_WORDS && store_mark[e] && e - pos < RUN_LIMIT) e++;
                            run_stop = e;
                            res.stream_byte = 8'(2 * (e - pos) + 3);
                            phase = PH_ADDR_HI;
                        end
                        PH_ADDR_HI: begin
                            res.stream_byte = {2'b0, 6'(pos >> 6)};
                            phase = PH_ADDR_LO;
                        end
                        PH_ADDR_LO: begin
                            res.stream_byte = {2'b0, 6'(pos)};
                            if (pos >= run_stop) res.stream_last = seek_run();
                            else phase = PH_WORD_HI;
                        end
                        PH_WORD_HI: begin
                            res.stream_byte = {2'b0, store_word[pos][11:6]};
                            phase = PH_WORD_LO;
                        end
                        default: begin
                            res.stream_byte = {2'b0, store_word[pos][5:0]};
                            pos++;
                            if (pos >= run_stop) res.stream_last = seek_run();
                            else phase = PH_WORD_HI;
                        end
                    endcase
                end
            end
        endcase
        res.error_total = err_count;
        return res;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // monitor: results first, since a result taken now belongs to an older request
    always @(posedge i_clk) begin
        t_result want;
        t_plan   took;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sparse_memory_object_emitter: mismatch");
            $finish;
        end else begin
            out_took = res_bus.valid && res_bus.ready && i_rst_n;
            in_took  = req_bus.valid && req_bus.ready && i_rst_n;
            if (out_took) begin
                res_count++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("read_word", want.read_word, res_bus.read_word);
                    check_field("stream_byte", want.stream_byte, res_bus.stream_byte);
                    check_field("byte_valid", want.byte_valid, res_bus.byte_valid);
                    check_field("stream_last", want.stream_last, res_bus.stream_last);
                    check_field("redefine_error", want.redefine_error,
                                res_bus.redefine_error);
                    check_field("error_total", want.error_total, res_bus.error_total);
                end
            end
            if (in_took) begin
                took.act   = ACT_REQ;
                took.kind  = req_bus.req_type;
                took.addr  = req_bus.word_address;
                took.val   = req_bus.word_value;
                took.allow = req_bus.allow_redefine;
                took.gap   = 0;
                expected_results.push_back(predict_result(took));
            end
            if (psel && penable && pwrite && pready && paddr == 3'd0)
                entry_reg = pwdata[11:0];
        end
    end

    // driver
    t_plan cur;
    logic  have_cur;
    int    cur_wait;
    int    settle;
    int    apb_stage;

    always @(negedge i_clk) begin
        logic v;
        v = req_bus.valid;
        if (i_rst_n) begin
            if (in_took) v = 1'b0;
            if (apb_stage == 1) begin
                penable   <= 1'b1;
                apb_stage = 2;
            end else if (apb_stage == 2) begin
                psel      <= 1'b0;
                penable   <= 1'b0;
                pwrite    <= 1'b0;
                apb_stage = 0;
            end else if (!v) begin
                if (!have_cur && req_plan.size() > 0 && req_plan[0].act == ACT_REQ) begin
                    cur      = req_plan.pop_front();
                    have_cur = 1'b1;
                    cur_wait = cur.gap;
                end
                if (have_cur) begin
                    if (cur_wait > 0) begin
                        cur_wait--;
                    end else begin
                        v        = 1'b1;
                        have_cur = 1'b0;
                        req_bus.req_type       <= cur.kind;
                        req_bus.word_address   <= cur.addr;
                        req_bus.word_value     <= cur.val;
                        req_bus.allow_redefine <= cur.allow;
                    end
                end else if (req_plan.size() > 0) begin
                    case (req_plan[0].act)
                        ACT_SYNC: begin
                            if (expected_results.size() == 0) begin
                                if (settle < req_plan[0].gap) begin
                                    settle++;
                                end else begin
                                    settle = 0;
                                    void'(req_plan.pop_front());
                                end
                            end
                        end
                        ACT_ENTRY: begin
                            psel      <= 1'b1;
                            pwrite    <= 1'b1;
                            paddr     <= 3'd0;
                            pwdata    <= {20'd0, req_plan[0].val};
                            apb_stage = 1;
                            void'(req_plan.pop_front());
                        end
                        default: begin
                            rx_hold_req = 1'b1;
                            void'(req_plan.pop_front());
                        end
                    endcase
                end else begin
                    feeding_done = 1'b1;
                end
            end
        end
        req_bus.valid <= v;
    end

    // receiver: random stalls, quiet stretches, and one long hold-off
    int stall_left;
    int hold_left;

    always @(negedge i_clk) begin
        logic rdy;
        logic quiet;
        quiet = ((res_count / 150) % 4) == 1;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left   = RX_HOLD_CYCLES;
            rdy         = 1'b0;
        end else if (out_took) begin
            stall_left = quiet ? 0 : $urandom_range(0, 14);
            rdy        = (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = (stall_left == 0);
        end else begin
            rdy = 1'b1;
        end
        res_bus.ready <= rdy && i_rst_n;
    end

    logic quiet_tx;

    task automatic add_req(input logic [1:0] kind, input logic [11:0] addr,
                           input logic [11:0] val, input logic allow);
        t_plan p;
        p.act   = ACT_REQ;
        p.kind  = kind;
        p.addr  = addr;
        p.val   = val;
        p.allow = allow;
        p.gap   = quiet_tx ? 0 : $urandom_range(0, 14);
        req_plan.push_back(p);
        n_items++;
    endtask

    task automatic add_ctrl(input t_act act, input logic [11:0] val, input int gap);
        t_plan p;
        p.act   = act;
        p.kind  = REQ_CLEAR;
        p.addr  = 12'd0;
        p.val   = val;
        p.allow = 1'b0;
        p.gap   = gap;
        req_plan.push_back(p);
    endtask

    initial begin
        int s;
        int base;
        int len;
        int r;
        logic [11:0] a;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_FETCH;
        req_bus.word_address = 12'd0;
        req_bus.word_value = 12'd0;
        req_bus.allow_redefine = 1'b0;
        res_bus.ready = 1'b0;
        in_took = 1'b0;
        out_took = 1'b0;
        rx_hold_req = 1'b0;
        feeding_done = 1'b0;
        have_cur = 1'b0;
        cur_wait = 0;
        settle = 0;
        apb_stage = 0;
        stall_left = 0;
        hold_left = 0;
        fail_count = 0;
        n_items = 0;
        cycles = 0;
        res_count = 0;
        quiet_tx = 1'b0;
        foreach (store_mark[i]) begin
            store_mark[i] = 1'b0;
            store_word[i] = 12'd0;
        end
        err_count = 16'd0;
        phase = PH_MAGIC0;
        pos = 0;
        run_stop = 0;
        entry_reg = 12'd0;

        // wait out the mark sweep after reset, then set the entry address
        add_ctrl(ACT_SYNC, 12'd0, STORE_WORDS + 100);
        add_ctrl(ACT_ENTRY, 12'hFFF, 0);
        // empty store: header only, then the restart
        repeat (7) add_req(REQ_EMIT, 12'd0, 12'd0, 1'b0);
        add_req(REQ_DEFINE, 12'd0, 12'hFFF, 1'b0);
        add_req(REQ_DEFINE, 12'd0, 12'h555, 1'b0);
        add_req(REQ_DEFINE, 12'd0, 12'h000, 1'b1);
        add_req(REQ_DEFINE, 12'hFFF, 12'hABC, 1'b0);
        add_req(REQ_FETCH, 12'd0, 12'd0, 1'b0);
        add_req(REQ_FETCH, 12'hFFF, 12'd0, 1'b0);
        add_req(REQ_FETCH, 12'd5, 12'd0, 1'b0);
        // clear part-way through the stream
        repeat (5) add_req(REQ_EMIT, 12'd0, 12'd0, 1'b0);
        add_req(REQ_CLEAR, 12'd0, 12'd0, 1'b0);
        add_req(REQ_FETCH, 12'hFFF, 12'd0, 1'b0);
        add_req(REQ_EMIT, 12'd0, 12'd0, 1'b0);

        s = 0;
        while (n_items < ITEM_TARGET) begin
            if (s % 6 == 3) begin
                add_ctrl(ACT_SYNC, 12'd0, 30);
                add_ctrl(ACT_ENTRY, (s % 12 == 3) ? 12'd0 :
                         (s % 12 == 9) ? 12'hFFF : 12'($urandom_range(0, 4095)), 0);
            end
            if (s == 4) add_ctrl(ACT_RX_HOLD, 12'd0, 0);
            if (s == 7) add_ctrl(ACT_SYNC, 12'd0, 0);
            quiet_tx = (s % 4 == 1);
            if ($urandom_range(0, 2) == 0) add_req(REQ_CLEAR, 12'd0, 12'd0, 1'b0);
            if (s % 9 == 5) begin
                // long run to cross the run length limit
                base = $urandom_range(0, STORE_WORDS - 141);
                len  = $urandom_range(RUN_LIMIT + 1, 140);
                for (int i = 0; i < len; i++)
                    add_req(REQ_DEFINE, 12'(base + i), 12'($urandom),
                            1'($urandom_range(0, 1)));
                repeat (40) add_req(($urandom_range(0, 9) == 0) ? REQ_FETCH : REQ_EMIT,
                                    12'(base + $urandom_range(0, len - 1)), 12'd0, 1'b0);
            end else begin
                base = $urandom_range(0, STORE_WORDS - 64);
                for (int i = 0; i < 70; i++) begin
                    r = $urandom_range(0, 99);
                    a = ($urandom_range(0, 9) != 0) ? 12'(base + $urandom_range(0, 63))
                                                    : 12'($urandom_range(0, 4095));
                    if (r < 38)
                        add_req(REQ_DEFINE, a, 12'($urandom), 1'($urandom_range(0, 1)));
                    else if (r < 62)
                        add_req(REQ_FETCH, a, 12'($urandom), 1'($urandom_range(0, 1)));
                    else if (r < 99)
                        add_req(REQ_EMIT, a, 12'($urandom), 1'($urandom_range(0, 1)));
                    else
                        add_req(REQ_CLEAR, a, 12'($urandom), 1'($urandom_range(0, 1)));
                end
            end
            s++;
        end
        add_ctrl(ACT_SYNC, 12'd0, 50);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (feeding_done);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("sparse_memory_object_emitter: match");
        end else begin
            $display("sparse_memory_object_emitter: mismatch");
        end
        $finish;
    end

endmodule
